// ===== sv/bbpe_pkg.sv =====
// Shared types and constants for the bicubic Bezier patch evaluator.
`timescale 1ns / 1ps
package bbpe_pkg;

	localparam int GRID_DIM   = 4;
	localparam int GRID_SIZE  = GRID_DIM * GRID_DIM;
	localparam int IDX_BITS   = $clog2(GRID_SIZE);
	localparam int DIM_BITS   = $clog2(GRID_DIM);
	localparam int PARAM_BITS = 17;
	localparam int FRAC_BITS  = 16;
	localparam int WGT_BITS   = 31;
	localparam int WGT_STEPS  = 3;

	localparam logic [PARAM_BITS-1:0] PARAM_ONE = PARAM_BITS'(1 << FRAC_BITS);

	localparam logic [1:0] BINOM3 [GRID_DIM] = '{2'd1, 2'd3, 2'd3, 2'd1};

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WGT,
		ST_MAC,
		ST_DRAIN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic                grid_we;
		logic                cap;
		logic                w1;
		logic                w2;
		logic                w3;
		logic                issue;
		logic [IDX_BITS-1:0] addr;
		logic                out_ld;
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} status_t;

endpackage

// ===== sv/bicubic_bezier_patch_eval.sv =====
// Bicubic Bezier patch evaluator top level: controller plus datapath.
// A load item (mode 0) writes one of the 16 control points; all 16 must be
// loaded before the first evaluate item. An evaluate item (mode 1) first forms the
// cubic Bernstein weights in u and v, then feeds the 16 control points one at a time
// into the shared multiply-accumulate, drains its pipeline, and rounds and saturates
// the sums into the output register, where its result becomes valid. The input is
// stalled while an evaluation runs and is taken again in the cycle after the result
// is loaded, so a new evaluate item is not taken before the last one is through; a
// finished result may wait in the output register while the next item is taken.
`timescale 1ns / 1ps
module bicubic_bezier_patch_eval #(
	parameter int COORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  logic [1:0]                          point_row,
	input  logic [1:0]                          point_col,
	input  logic signed [COORD_BITS-1:0]        coord_x,
	input  logic signed [COORD_BITS-1:0]        coord_y,
	input  logic signed [COORD_BITS-1:0]        coord_z,
	input  logic [bbpe_pkg::PARAM_BITS-1:0]     param_u,
	input  logic [bbpe_pkg::PARAM_BITS-1:0]     param_v,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [COORD_BITS-1:0]        surf_x,
	output logic signed [COORD_BITS-1:0]        surf_y,
	output logic signed [COORD_BITS-1:0]        surf_z
);
	import bbpe_pkg::*;

	cmd_t    cmd;
	status_t status;

	bbpe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	bbpe_dp #(
		.CB (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.point_row (point_row),
		.point_col (point_col),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.coord_z   (coord_z),
		.param_u   (param_u),
		.param_v   (param_v),
		.surf_x    (surf_x),
		.surf_y    (surf_y),
		.surf_z    (surf_z)
	);

endmodule

// ===== sv/bbpe_ctrl.sv =====
// Sequencer for the patch evaluator: loads, weight steps, point walk, drain, result.
`timescale 1ns / 1ps
module bbpe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	output logic              out_valid,
	input  logic              out_stall,
	input  bbpe_pkg::status_t status,
	output bbpe_pkg::cmd_t    cmd
);
	import bbpe_pkg::*;

	state_t              state_q, state_d;
	logic [IDX_BITS-1:0] cnt_q;
	logic                out_valid_q;
	logic                accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (mode == MODE_EVAL))
					state_d = ST_WGT;
			end
			ST_WGT: begin
				if (cnt_q == IDX_BITS'(WGT_STEPS - 1))
					state_d = ST_MAC;
			end
			ST_MAC: begin
				if (cnt_q == IDX_BITS'(GRID_SIZE - 1))
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!status.pipe_busy)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.addr = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.grid_we = accept && (mode == MODE_LOAD);
				cmd.cap     = accept && (mode == MODE_EVAL);
			end
			ST_WGT: begin
				cmd.w1 = (cnt_q == IDX_BITS'(0));
				cmd.w2 = (cnt_q == IDX_BITS'(1));
				cmd.w3 = (cnt_q == IDX_BITS'(2));
			end
			ST_MAC: begin
				cmd.issue = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_FIN: begin
				cmd.out_ld = !out_valid_q || !out_stall;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + IDX_BITS'(1);
			if (cmd.out_ld)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/bbpe_dp.sv =====
// Datapath: control grid, Bernstein weights, shared multiply-accumulate, rounding and saturation.
`timescale 1ns / 1ps
module bbpe_dp #(
	parameter int CB = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bbpe_pkg::cmd_t                       cmd,
	output bbpe_pkg::status_t                    status,
	input  logic [1:0]                           point_row,
	input  logic [1:0]                           point_col,
	input  logic signed [CB-1:0]                 coord_x,
	input  logic signed [CB-1:0]                 coord_y,
	input  logic signed [CB-1:0]                 coord_z,
	input  logic [bbpe_pkg::PARAM_BITS-1:0]      param_u,
	input  logic [bbpe_pkg::PARAM_BITS-1:0]      param_v,
	output logic signed [CB-1:0]                 surf_x,
	output logic signed [CB-1:0]                 surf_y,
	output logic signed [CB-1:0]                 surf_z
);
	import bbpe_pkg::*;

	localparam int P1_BITS  = 2 * PARAM_BITS - 1;
	localparam int P2_BITS  = 3 * FRAC_BITS + 1;
	localparam int T_BITS   = P2_BITS + 2;
	localparam int BSH      = 3 * FRAC_BITS - (WGT_BITS - 1);
	localparam int WP_BITS  = 2 * WGT_BITS;
	localparam int WSH      = WGT_BITS - 1;
	localparam int ACC_W    = CB + 32;
	localparam int R_W      = ACC_W - WSH;
	localparam int LANES    = 3;

	// grid and weight state
	logic [LANES*CB-1:0]   grid_q [GRID_SIZE];
	logic [PARAM_BITS-1:0] ua_q, ub_q, va_q, vb_q;
	logic [P1_BITS-1:0]    up1_q [GRID_DIM];
	logic [P1_BITS-1:0]    vp1_q [GRID_DIM];
	logic [P2_BITS-1:0]    up2_q [GRID_DIM];
	logic [P2_BITS-1:0]    vp2_q [GRID_DIM];
	logic [WGT_BITS-1:0]   bu_q  [GRID_DIM];
	logic [WGT_BITS-1:0]   bv_q  [GRID_DIM];

	// multiply-accumulate pipeline
	logic                     v_s1, v_s2, v_s3, v_s4;
	logic [LANES*CB-1:0]      pt_s1, pt_s2, pt_s3;
	logic [WGT_BITS-1:0]      bu_s1, bv_s1, w_s3;
	logic [WP_BITS-1:0]       wp_s2;
	logic signed [ACC_W-1:0]  m_s4  [LANES];
	logic signed [ACC_W-1:0]  acc_q [LANES];
	logic signed [CB-1:0]     surf_q [LANES];

	logic [PARAM_BITS-1:0] ua_d, ub_d, va_d, vb_d;
	logic [WP_BITS-1:0]    wrnd;

	function automatic logic [PARAM_BITS-1:0] factor(input int i, input int n,
			input logic [PARAM_BITS-1:0] a, input logic [PARAM_BITS-1:0] b);
		return (n < i) ? a : b;
	endfunction

	function automatic logic [WGT_BITS-1:0] round_bern(input logic [P2_BITS-1:0] p,
			input logic [1:0] c);
		logic [T_BITS-1:0] t;
		t = T_BITS'(p) * T_BITS'(c) + T_BITS'(64'd1 << (BSH - 1));
		return t[BSH +: WGT_BITS];
	endfunction

	function automatic logic signed [CB-1:0] saturate(input logic signed [ACC_W-1:0] acc);
		logic [ACC_W-1:0] rnd;
		logic [R_W-1:0]   r;
		rnd = acc + ACC_W'(64'd1 << (WSH - 1));
		r   = rnd[ACC_W-1:WSH];
		if ((r[R_W-1:CB-1] == '0) || (r[R_W-1:CB-1] == '1))
			return r[CB-1:0];
		else if (r[R_W-1])
			return {1'b1, {(CB-1){1'b0}}};
		else
			return {1'b0, {(CB-1){1'b1}}};
	endfunction

	always_comb begin
		ua_d = param_u[PARAM_BITS-1] ? PARAM_ONE : param_u;
		va_d = param_v[PARAM_BITS-1] ? PARAM_ONE : param_v;
		ub_d = PARAM_ONE - ua_d;
		vb_d = PARAM_ONE - va_d;
		wrnd = wp_s2 + WP_BITS'(64'd1 << (WSH - 1));
	end

	always_ff @(posedge clk) begin
		if (cmd.grid_we)
			grid_q[{point_row, point_col}] <= {coord_z, coord_y, coord_x};
		if (cmd.cap) begin
			ua_q <= ua_d;
			ub_q <= ub_d;
			va_q <= va_d;
			vb_q <= vb_d;
		end
		for (int i = 0; i < GRID_DIM; i++) begin
			if (cmd.w1) begin
				up1_q[i] <= P1_BITS'(factor(i, 0, ua_q, ub_q) * factor(i, 1, ua_q, ub_q));
				vp1_q[i] <= P1_BITS'(factor(i, 0, va_q, vb_q) * factor(i, 1, va_q, vb_q));
			end
			if (cmd.w2) begin
				up2_q[i] <= P2_BITS'(up1_q[i] * factor(i, 2, ua_q, ub_q));
				vp2_q[i] <= P2_BITS'(vp1_q[i] * factor(i, 2, va_q, vb_q));
			end
			if (cmd.w3) begin
				bu_q[i] <= round_bern(up2_q[i], BINOM3[i]);
				bv_q[i] <= round_bern(vp2_q[i], BINOM3[i]);
			end
		end
		if (cmd.issue) begin
			pt_s1 <= grid_q[cmd.addr];
			bu_s1 <= bu_q[cmd.addr[IDX_BITS-1:DIM_BITS]];
			bv_s1 <= bv_q[cmd.addr[DIM_BITS-1:0]];
		end
		wp_s2 <= bu_s1 * bv_s1;
		pt_s2 <= pt_s1;
		w_s3  <= wrnd[WSH +: WGT_BITS];
		pt_s3 <= pt_s2;
		for (int c = 0; c < LANES; c++) begin
			m_s4[c] <= ACC_W'($signed({1'b0, w_s3}) * $signed(pt_s3[c*CB +: CB]));
			if (cmd.cap)
				acc_q[c] <= '0;
			else if (v_s4)
				acc_q[c] <= acc_q[c] + m_s4[c];
			if (cmd.out_ld)
				surf_q[c] <= saturate(acc_q[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign status.pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;
	assign surf_x = surf_q[0];
	assign surf_y = surf_q[1];
	assign surf_z = surf_q[2];

endmodule
